// File: hw/rtl/drum_sample_voice_mixer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the drum sample voice mixer
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DRUM_SAMPLE_VOICE_MIXER_CORE_MACROS_SVH
`define DRUM_SAMPLE_VOICE_MIXER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DSVM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define DSVM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dsvm_pkg.sv
// ----------------------------------------------------------------------------
// dsvm_pkg
// Shared widths, codes and types of the drum sample voice mixer.
// ----------------------------------------------------------------------------
package dsvm_pkg;

    localparam int VOICES       = 5;
    // words per voice region; a power of two so a region base is a shift
    localparam int SAMPLE_WORDS = 16384;
    localparam int WORD_AW      = $clog2(SAMPLE_WORDS);
    localparam int MEM_DEPTH    = VOICES * SAMPLE_WORDS;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int VCNT_W       = $clog2(VOICES);

    // fixed field widths
    localparam int ACTION_W     = 2;
    localparam int CHAN_W       = 4;
    localparam int NOTE_W       = 7;
    localparam int LVOICE_W     = 3;
    localparam int LADDR_W      = 14;
    localparam int SWORD_W      = 16;
    localparam int LEN_W        = 15;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DW       = 15;
    localparam int SUM_W        = 19;
    localparam int MIX_W        = 35;
    localparam int GAIN_SHIFT   = 16;

    localparam logic signed [MIX_W-1:0] MIX_MIN = -35'sd10737254400;
    localparam logic signed [MIX_W-1:0] MIX_MAX = 35'sd10736926725;

    // input actions
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NOTE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_0        = 3'd1;

    // note numbers
    localparam logic [NOTE_W-1:0] NOTE_BASS      = 7'd36;
    localparam logic [NOTE_W-1:0] NOTE_SNARE     = 7'd38;
    localparam logic [NOTE_W-1:0] NOTE_RIM       = 7'd39;
    localparam logic [NOTE_W-1:0] NOTE_HH_OPEN   = 7'd42;
    localparam logic [NOTE_W-1:0] NOTE_HH_CLOSED = 7'd44;

    localparam logic [VCNT_W-1:0] VOICE_HH_OPEN   = 3'd3;
    localparam logic [VCNT_W-1:0] VOICE_HH_CLOSED = 3'd4;

    // one voice slot of a tick, from the voice sequencer to the mixer
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              use_word;
        logic [VOICES-1:0] playing;
    } dsvm_tag_t;

endpackage

// File: hw/rtl/dsvm_sample_mem.sv
// ----------------------------------------------------------------------------
// dsvm_sample_mem
// Sample word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dsvm_sample_mem
    import dsvm_pkg::*;
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [MEM_AW-1:0]         wr_addr,
    input  logic signed [SWORD_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [MEM_AW-1:0]         rd_addr,
    output logic signed [SWORD_W-1:0] rd_data
);

    logic signed [SWORD_W-1:0] mem [MEM_DEPTH];
    logic signed [SWORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/dsvm_voice_ctrl.sv
// ----------------------------------------------------------------------------
// dsvm_voice_ctrl
// Configuration, voice state and the tick sequencer that walks the voices.
// ----------------------------------------------------------------------------
module dsvm_voice_ctrl
    import dsvm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DW-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACTION_W-1:0]       action,
    input  logic [CHAN_W-1:0]         event_channel,
    input  logic [NOTE_W-1:0]         note_number,
    input  logic [LVOICE_W-1:0]       load_voice,
    input  logic [LADDR_W-1:0]        load_address,
    input  logic signed [SWORD_W-1:0] load_word,
    input  logic                      mix_busy,
    output logic                      mem_wr_en,
    output logic [MEM_AW-1:0]         mem_wr_addr,
    output logic signed [SWORD_W-1:0] mem_wr_data,
    output logic                      mem_rd_en,
    output logic [MEM_AW-1:0]         mem_rd_addr,
    output dsvm_tag_t                 tag
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic                                 state_reg, state_next;
    logic [VCNT_W-1:0]                    vcnt_reg, vcnt_next;
    logic [VOICES-1:0][WORD_AW-1:0]       pos_reg, pos_next;
    logic [VOICES-1:0]                    act_reg, act_next;
    logic [VOICES-1:0]                    playing_reg, playing_next;
    dsvm_tag_t                            tag_reg, tag_next;
    logic [CHAN_W-1:0]                    chan_reg, chan_next;
    logic [VOICES-1:0][LEN_W-1:0]         len_reg, len_next;
    logic [VOICES-1:0][LEN_W-1:0]         eff_len;

    logic                                 accept;
    logic                                 note_hit;
    logic [VCNT_W-1:0]                    note_voice;
    logic [WORD_AW-1:0]                   cur_pos;
    logic                                 at_end;
    logic [VCNT_W-1:0]                    cfg_voice;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !tag_reg.valid && !mix_busy;

    // clamp lengths to the region size
    always_comb
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            eff_len[v] = (32'(len_reg[v]) > SAMPLE_WORDS) ? LEN_W'(SAMPLE_WORDS) : len_reg[v];
        end
    end

    // configuration writes
    assign cfg_voice = VCNT_W'(cfg_index - REG_LEN_0);

    always_comb
    begin
        chan_next = chan_reg;
        len_next  = len_reg;
        if (cfg_wr_en)
        begin
            if (cfg_index == REG_MIDI_CHANNEL)
            begin
                chan_next = cfg_data[CHAN_W-1:0];
            end
            else if (cfg_index >= REG_LEN_0 &&
                     32'(cfg_index) < 32'(REG_LEN_0) + VOICES)
            begin
                len_next[cfg_voice] = cfg_data[LEN_W-1:0];
            end
        end
    end

    // note to voice decode
    always_comb
    begin
        note_hit   = 1'b1;
        note_voice = '0;
        unique case (note_number)
            NOTE_BASS:      note_voice = 3'd0;
            NOTE_SNARE:     note_voice = 3'd1;
            NOTE_RIM:       note_voice = 3'd2;
            NOTE_HH_OPEN:   note_voice = VOICE_HH_OPEN;
            NOTE_HH_CLOSED: note_voice = VOICE_HH_CLOSED;
            default:        note_hit   = 1'b0;
        endcase
    end

    assign cur_pos     = pos_reg[vcnt_reg];
    assign at_end      = (32'(cur_pos) + 1) >= 32'(eff_len[vcnt_reg]);
    assign mem_rd_en   = (state_reg == ST_TICK);
    assign mem_rd_addr = (MEM_AW'(vcnt_reg) << WORD_AW) | MEM_AW'(cur_pos);
    assign mem_wr_addr = (MEM_AW'(load_voice) << WORD_AW) | MEM_AW'(load_address);
    assign mem_wr_data = load_word;

    always_comb
    begin
        state_next   = state_reg;
        vcnt_next    = vcnt_reg;
        pos_next     = pos_reg;
        act_next     = act_reg;
        playing_next = playing_reg;
        tag_next     = '0;
        mem_wr_en    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_TICK:
                        begin
                            state_next   = ST_TICK;
                            vcnt_next    = '0;
                            playing_next = '0;
                        end
                        ACT_NOTE:
                        begin
                            if (event_channel == chan_reg && note_hit)
                            begin
                                // restart; an empty sample never starts
                                pos_next[note_voice] = '0;
                                act_next[note_voice] = (eff_len[note_voice] != '0);
                                if (note_voice == VOICE_HH_CLOSED)
                                begin
                                    // choke the open hi-hat
                                    pos_next[VOICE_HH_OPEN] = '0;
                                    act_next[VOICE_HH_OPEN] = 1'b0;
                                end
                            end
                        end
                        ACT_LOAD:
                        begin
                            mem_wr_en = (32'(load_voice) < VOICES) &&
                                        (32'(load_address) < SAMPLE_WORDS);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (act_reg[vcnt_reg])
                begin
                    if (at_end)
                    begin
                        pos_next[vcnt_reg] = '0;
                        act_next[vcnt_reg] = 1'b0;
                    end
                    else
                    begin
                        pos_next[vcnt_reg]     = cur_pos + 1'b1;
                        playing_next[vcnt_reg] = 1'b1;
                    end
                end
                tag_next.valid    = 1'b1;
                tag_next.first    = (vcnt_reg == '0);
                tag_next.last     = (32'(vcnt_reg) == VOICES - 1);
                tag_next.use_word = act_reg[vcnt_reg];
                tag_next.playing  = playing_next;
                if (32'(vcnt_reg) == VOICES - 1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    vcnt_next = vcnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vcnt_reg    <= '0;
            pos_reg     <= '0;
            act_reg     <= '0;
            playing_reg <= '0;
            tag_reg     <= '0;
            chan_reg    <= '0;
            len_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            vcnt_reg    <= vcnt_next;
            pos_reg     <= pos_next;
            act_reg     <= act_next;
            playing_reg <= playing_next;
            tag_reg     <= tag_next;
            chan_reg    <= chan_next;
            len_reg     <= len_next;
        end
    end

    assign tag = tag_reg;

endmodule

// File: hw/rtl/dsvm_mix.sv
// ----------------------------------------------------------------------------
// dsvm_mix
// Sums the voice words of a tick, applies the gain and holds the result beat.
// ----------------------------------------------------------------------------
module dsvm_mix
    import dsvm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dsvm_tag_t                 tag,
    input  logic signed [SWORD_W-1:0] rd_data,
    output logic                      mix_busy,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [MIX_W-1:0]   mix_out,
    output logic [VOICES-1:0]         voices_playing
);

    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic                    sum_valid_reg, sum_valid_next;
    logic [VOICES-1:0]       hold_playing_reg, hold_playing_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [MIX_W-1:0] mix_reg, mix_next;
    logic [VOICES-1:0]       playing_reg, playing_next;

    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] total;
    logic signed [MIX_W-1:0] sum_ext;
    logic                    move;

    assign term    = tag.use_word ? SUM_W'(rd_data) : '0;
    assign total   = (tag.first ? '0 : acc_reg) + term;
    assign sum_ext = MIX_W'(sum_reg);
    // gain of 0xffff: shift up and subtract once
    assign move    = sum_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        acc_next          = acc_reg;
        sum_next          = sum_reg;
        sum_valid_next    = sum_valid_reg;
        hold_playing_next = hold_playing_reg;
        out_valid_next    = out_valid_reg;
        mix_next          = mix_reg;
        playing_next      = playing_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
            mix_next       = (sum_ext <<< GAIN_SHIFT) - sum_ext;
            playing_next   = hold_playing_reg;
            sum_valid_next = 1'b0;
        end
        if (tag.valid)
        begin
            acc_next = total;
            if (tag.last)
            begin
                sum_next          = total;
                sum_valid_next    = 1'b1;
                hold_playing_next = tag.playing;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        sum_reg          <= sum_next;
        hold_playing_reg <= hold_playing_next;
        mix_reg          <= mix_next;
        playing_reg      <= playing_next;
    end

    assign mix_busy       = sum_valid_reg;
    assign out_valid      = out_valid_reg;
    assign mix_out        = mix_reg;
    assign voices_playing = playing_reg;

endmodule

// File: hw/rtl/drum_sample_voice_mixer_core.sv
// ----------------------------------------------------------------------------
// drum_sample_voice_mixer_core
// Five-voice one-shot drum sample player with a shared sample memory.
//
// Channel   Direction  Handshake            Beat
// in        input      in_valid/in_ready    tick, note-on or sample load
// out       output     out_valid/out_ready  mix_out, voices_playing per tick
// cfg       input      cfg_wr_en            channel and sample lengths
//
// Note-on and load beats complete as they are accepted. A tick makes one
// read of the shared sample memory port per voice, then a sum stage and a
// gain stage. The next beat is taken once the sum has moved to the output
// register, which may still be waiting for out_ready. Reset clears the
// voice and configuration state; sample memory is undefined until loaded.
// ----------------------------------------------------------------------------
module drum_sample_voice_mixer_core
    import dsvm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DW-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACTION_W-1:0]       action,
    input  logic [CHAN_W-1:0]         event_channel,
    input  logic [NOTE_W-1:0]         note_number,
    input  logic [LVOICE_W-1:0]       load_voice,
    input  logic [LADDR_W-1:0]        load_address,
    input  logic signed [SWORD_W-1:0] load_word,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [MIX_W-1:0]   mix_out,
    output logic [VOICES-1:0]         voices_playing
);

    logic                      mem_wr_en;
    logic [MEM_AW-1:0]         mem_wr_addr;
    logic signed [SWORD_W-1:0] mem_wr_data;
    logic                      mem_rd_en;
    logic [MEM_AW-1:0]         mem_rd_addr;
    logic signed [SWORD_W-1:0] mem_rd_data;
    logic                      mix_busy;
    dsvm_tag_t                 tag;

    dsvm_voice_ctrl u_voice_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .event_channel (event_channel),
        .note_number   (note_number),
        .load_voice    (load_voice),
        .load_address  (load_address),
        .load_word     (load_word),
        .mix_busy      (mix_busy),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .tag           (tag)
    );

    dsvm_sample_mem u_sample_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    dsvm_mix u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .tag            (tag),
        .rd_data        (mem_rd_data),
        .mix_busy       (mix_busy),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mix_out        (mix_out),
        .voices_playing (voices_playing)
    );

endmodule

// File: hw/rtl/dsvm_checker.sv
// ----------------------------------------------------------------------------
// dsvm_checker
// Port-level checks of the drum sample voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "drum_sample_voice_mixer_core_macros.svh"

module dsvm_checker
    import dsvm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [ACTION_W-1:0]       action,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [MIX_W-1:0]   mix_out,
    input logic [VOICES-1:0]         voices_playing
);

    `DSVM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(mix_out) && $stable(voices_playing), "output beat changed while stalled")
    `DSVM_ASSERT_SAME(a_mix_range, out_valid, mix_out >= MIX_MIN && mix_out <= MIX_MAX,
        "mix_out outside the reachable range")
    `DSVM_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && action == ACT_TICK, !in_ready,
        "input ready right after a tick beat")
    `DSVM_ASSERT_NEXT(a_short_ready, in_valid && in_ready && action != ACT_TICK, in_ready,
        "input not ready after a note or load beat")

endmodule

bind drum_sample_voice_mixer_core dsvm_checker u_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for drum_sample_voice_mixer_core. Drives tick, note-on and
// sample-load beats with bursty timing and a stalling result sink, tracks
// the voices and sample memory in a shadow model and checks every mix
// result against it in order. Directed cases come first, then random
// phases with a fresh channel and sample lengths each.
// ----------------------------------------------------------------------------
module tb;
    import dsvm_pkg::*;

    localparam int     LIMIT_NS      = 4_000_000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     PHASES        = 6;
    localparam int     PHASE_BEATS   = 300;
    localparam int     VOICE_BASS    = 0;
    localparam int     VOICE_SNARE   = 1;
    localparam int     VOICE_RIM     = 2;
    localparam longint MIX_GAIN      = 64'hffff;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       act;
        logic [CHAN_W-1:0]         chan;
        logic [NOTE_W-1:0]         note;
        logic [LVOICE_W-1:0]       voice;
        logic [LADDR_W-1:0]        addr;
        logic signed [SWORD_W-1:0] word;
    } drum_beat_t;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix;
        logic [VOICES-1:0]       playing;
    } mix_result_t;

    logic                      clk            = 1'b0;
    logic                      rst_n          = 1'b0;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_DW-1:0]         cfg_data       = '0;
    logic                      in_valid       = 1'b0;
    wire                       in_ready;
    logic [ACTION_W-1:0]       action         = '0;
    logic [CHAN_W-1:0]         event_channel  = '0;
    logic [NOTE_W-1:0]         note_number    = '0;
    logic [LVOICE_W-1:0]       load_voice     = '0;
    logic [LADDR_W-1:0]        load_address   = '0;
    logic signed [SWORD_W-1:0] load_word      = '0;
    wire                       out_valid;
    logic                      out_ready      = 1'b0;
    wire signed [MIX_W-1:0]    mix_out;
    wire [VOICES-1:0]          voices_playing;

    // shadow of the block: registers, voices and sample memory
    logic [CHAN_W-1:0]         chan_shadow = '0;
    logic [LEN_W-1:0]          len_shadow [VOICES];
    int unsigned               play_pos [VOICES];
    bit                        voice_on [VOICES];
    logic signed [SWORD_W-1:0] sample_shadow [MEM_DEPTH];
    bit                        word_loaded [MEM_DEPTH];

    mix_result_t expected_mix_q [$];
    mix_result_t mix_head;

    int ticks_sent      = 0;
    int notes_sent      = 0;
    int loads_sent      = 0;
    int unused_sent     = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int burst_left      = 0;

    logic [15:0] sink_pat = '1;
    int          sink_cnt = 0;

    drum_sample_voice_mixer_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .event_channel  (event_channel),
        .note_number    (note_number),
        .load_voice     (load_voice),
        .load_address   (load_address),
        .load_word      (load_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mix_out        (mix_out),
        .voices_playing (voices_playing)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------
    function automatic int unsigned usable_len(int v);
        int unsigned n;
        n = len_shadow[v];
        return (n > SAMPLE_WORDS) ? SAMPLE_WORDS : n;
    endfunction

    function automatic int unsigned mem_slot(int v, int unsigned p);
        return v * SAMPLE_WORDS + p;
    endfunction

    function automatic void start_voice(int v);
        play_pos[v] = 0;
        voice_on[v] = (usable_len(v) != 0);
    endfunction

    function automatic void stop_voice(int v);
        play_pos[v] = 0;
        voice_on[v] = 1'b0;
    endfunction

    function automatic logic [NOTE_W-1:0] drum_note(int v);
        case (v)
            VOICE_BASS:      return NOTE_BASS;
            VOICE_SNARE:     return NOTE_SNARE;
            VOICE_RIM:       return NOTE_RIM;
            VOICE_HH_OPEN:   return NOTE_HH_OPEN;
            default:         return NOTE_HH_CLOSED;
        endcase
    endfunction

    function automatic int beats_total();
        return ticks_sent + notes_sent + loads_sent + unused_sent;
    endfunction

    // advance the shadow by one accepted beat; a tick queues its mix
    function automatic void track_beat(drum_beat_t b);
        mix_result_t r;
        longint      acc;
        int unsigned p;
        case (b.act)
            ACT_NOTE:
            begin
                notes_sent++;
                if (b.chan == chan_shadow)
                begin
                    case (b.note)
                        NOTE_BASS:      start_voice(VOICE_BASS);
                        NOTE_SNARE:     start_voice(VOICE_SNARE);
                        NOTE_RIM:       start_voice(VOICE_RIM);
                        NOTE_HH_OPEN:   start_voice(VOICE_HH_OPEN);
                        NOTE_HH_CLOSED:
                        begin
                            start_voice(VOICE_HH_CLOSED);
                            stop_voice(VOICE_HH_OPEN);
                        end
                        default: ;
                    endcase
                end
            end
            ACT_LOAD:
            begin
                loads_sent++;
                if (b.voice < VOICES)
                begin
                    sample_shadow[mem_slot(b.voice, b.addr)] = b.word;
                    word_loaded[mem_slot(b.voice, b.addr)]   = 1'b1;
                end
            end
            ACT_TICK:
            begin
                ticks_sent++;
                acc       = 0;
                r.playing = '0;
                for (int v = 0; v < VOICES; v++)
                begin
                    if (voice_on[v])
                    begin
                        p   = play_pos[v];
                        acc = acc + sample_shadow[mem_slot(v, p)];
                        p++;
                        if (p >= usable_len(v))
                            stop_voice(v);
                        else
                        begin
                            play_pos[v]  = p;
                            r.playing[v] = 1'b1;
                        end
                    end
                end
                r.mix = MIX_W'(acc * MIX_GAIN);
                expected_mix_q.push_back(r);
            end
            default: unused_sent++;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic drum_beat_t any_beat();
        drum_beat_t b;
        b.act   = ACTION_W'($urandom);
        b.chan  = CHAN_W'($urandom);
        b.note  = NOTE_W'($urandom);
        b.voice = LVOICE_W'($urandom);
        b.addr  = LADDR_W'($urandom);
        b.word  = SWORD_W'($urandom);
        return b;
    endfunction

    // bursts of random length, then a random gap; sometimes long runs back to back
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_beat(drum_beat_t b);
        @(negedge clk);
        in_valid      <= 1'b1;
        action        <= b.act;
        event_channel <= b.chan;
        note_number   <= b.note;
        load_voice    <= b.voice;
        load_address  <= b.addr;
        load_word     <= b.word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        track_beat(b);
        pace();
    endtask

    task automatic load_sample(int v, logic [LADDR_W-1:0] a, logic signed [SWORD_W-1:0] w);
        drum_beat_t b;
        b       = any_beat();
        b.act   = ACT_LOAD;
        b.voice = LVOICE_W'(v);
        b.addr  = a;
        b.word  = w;
        send_beat(b);
    endtask

    task automatic note_on(logic [NOTE_W-1:0] n);
        drum_beat_t b;
        b      = any_beat();
        b.act  = ACT_NOTE;
        b.chan = chan_shadow;
        b.note = n;
        send_beat(b);
    endtask

    // fill any word a playing voice is about to read, then tick
    task automatic play_tick();
        drum_beat_t b;
        for (int v = 0; v < VOICES; v++)
        begin
            if (voice_on[v] && !word_loaded[mem_slot(v, play_pos[v])])
                load_sample(v, LADDR_W'(play_pos[v]), SWORD_W'($urandom));
        end
        b     = any_beat();
        b.act = ACT_TICK;
        send_beat(b);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_MIDI_CHANNEL)
            chan_shadow = data[CHAN_W-1:0];
        else if (idx >= REG_LEN_0 && idx < REG_LEN_0 + VOICES)
            len_shadow[idx - REG_LEN_0] = data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid, wait out every pending mix plus the pipeline tail
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (sink_cnt == 0)
        begin
            sink_cnt <= $urandom_range(64, 400);
            case ($urandom_range(0, 2))
                0:       sink_pat <= '1;
                1:       sink_pat <= 16'($urandom) | 16'h1;
                default: sink_pat <= 16'($urandom & $urandom) | 16'h1;
            endcase
        end
        else
        begin
            sink_cnt <= sink_cnt - 1;
            sink_pat <= {sink_pat[0], sink_pat[15:1]};
        end
        out_ready <= sink_pat[0];
    end

    function automatic void log_mismatch(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %0d: %s", fail_count, msg);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_mix_q.size() == 0)
                log_mismatch($sformatf("mix beat with nothing pending: mix %0d playing %b",
                                       mix_out, voices_playing));
            else
            begin
                mix_head = expected_mix_q.pop_front();
                if (mix_out !== mix_head.mix)
                    log_mismatch($sformatf("mix_out expected %0d got %0d",
                                           mix_head.mix, mix_out));
                if (voices_playing !== mix_head.playing)
                    log_mismatch($sformatf("voices_playing expected %b got %b",
                                           mix_head.playing, voices_playing));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_after_reset();
        drum_beat_t b;
        play_tick();
        // zero length: the note must not start the voice
        note_on(NOTE_BASS);
        play_tick();
        b     = any_beat();
        b.act = ACT_UNUSED;
        send_beat(b);
        play_tick();
        drain();
    endtask

    task automatic test_mix_extremes();
        // channel 15, with the unused upper data bits set
        write_reg(REG_MIDI_CHANNEL, '1);
        for (int v = 0; v < VOICES; v++)
            write_reg(CFG_IDX_W'(REG_LEN_0 + v), 15'd2);
        for (int v = 0; v < VOICES; v++)
        begin
            load_sample(v, 14'd0, 16'sh7fff);
            load_sample(v, 14'd1, 16'sh8000);
        end
        // closed hat first so the open hat is not choked
        note_on(NOTE_HH_CLOSED);
        note_on(NOTE_BASS);
        note_on(NOTE_SNARE);
        note_on(NOTE_RIM);
        note_on(NOTE_HH_OPEN);
        repeat (3) play_tick();
    endtask

    task automatic test_notes_and_choke();
        drum_beat_t b;
        b      = any_beat();
        b.act  = ACT_NOTE;
        b.chan = chan_shadow ^ 4'd1;
        b.note = NOTE_BASS;
        send_beat(b);
        note_on(7'd0);
        note_on(7'd127);
        note_on(NOTE_BASS + 7'd1);
        note_on(NOTE_HH_OPEN + 7'd1);
        play_tick();
        note_on(NOTE_HH_OPEN);
        play_tick();
        // closed hat chokes the open hat mid-sample
        note_on(NOTE_HH_CLOSED);
        play_tick();
        note_on(NOTE_BASS);
        play_tick();
        // restart from the first word
        note_on(NOTE_BASS);
        repeat (3) play_tick();
    endtask

    task automatic test_bad_loads();
        drum_beat_t b;
        for (int v = VOICES; v < 8; v++)
        begin
            b       = any_beat();
            b.act   = ACT_LOAD;
            b.voice = LVOICE_W'(v);
            b.addr  = '0;
            send_beat(b);
        end
        load_sample(VOICE_HH_CLOSED, '1, SWORD_W'($urandom));
        note_on(NOTE_BASS);
        repeat (2) play_tick();
        drain();
    endtask

    task automatic test_length_change();
        write_reg(REG_LEN_0 + VOICE_HH_OPEN, LEN_W'(SAMPLE_WORDS));
        write_reg(REG_LEN_0 + VOICE_HH_CLOSED, '1);
        note_on(NOTE_HH_CLOSED);
        note_on(NOTE_HH_OPEN);
        repeat (5) play_tick();
        drain();
        // shrink below the current position: one more word, then stop
        write_reg(REG_LEN_0 + VOICE_HH_OPEN, 15'd2);
        write_reg(REG_LEN_0 + VOICE_HH_CLOSED, '0);
        repeat (2) play_tick();
        note_on(NOTE_HH_CLOSED);
        play_tick();
        drain();
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_W'(SAMPLE_WORDS);
            2:       return '1;
            3:       return LEN_W'($urandom_range(SAMPLE_WORDS + 1, 32766));
            default: return LEN_W'($urandom_range(1, 48));
        endcase
    endfunction

    // mostly well-formed traffic; the rest is mostly ignored beats
    task automatic random_beat();
        drum_beat_t b;
        int         pick;
        b       = any_beat();
        pick    = $urandom_range(0, 99);
        if (pick < 45)
            play_tick();
        else if (pick < 70)
        begin
            b.act  = ACT_NOTE;
            b.chan = chan_shadow;
            b.note = drum_note($urandom_range(0, VOICES - 1));
            send_beat(b);
        end
        else if (pick < 88)
        begin
            b.act   = ACT_LOAD;
            b.voice = LVOICE_W'($urandom_range(0, VOICES - 1));
            if ($urandom_range(0, 3) != 0)
                b.addr = LADDR_W'($urandom_range(0, 63));
            if ($urandom_range(0, 9) == 0)
                b.word = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            send_beat(b);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: b.act = ACT_UNUSED;
                1:
                begin
                    b.act  = ACT_NOTE;
                    b.chan = chan_shadow ^ CHAN_W'($urandom_range(1, 15));
                    b.note = drum_note($urandom_range(0, VOICES - 1));
                end
                2:
                begin
                    b.act  = ACT_NOTE;
                    b.chan = chan_shadow;
                end
                3:
                begin
                    b.act   = ACT_LOAD;
                    b.voice = LVOICE_W'($urandom_range(VOICES, 7));
                end
                default: b.act = ACT_NOTE;
            endcase
            send_beat(b);
        end
    endtask

    task automatic test_random_traffic();
        logic [CHAN_W-1:0] chan;
        int                start_beats;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            chan = (ph == 0) ? '0 : (ph == 1) ? '1 : CHAN_W'($urandom);
            write_reg(REG_MIDI_CHANNEL, CFG_DW'($urandom & ~32'hf) | CFG_DW'(chan));
            for (int v = 0; v < VOICES; v++)
                write_reg(CFG_IDX_W'(REG_LEN_0 + v), pick_length());
            // unused indexes must leave every register alone
            if (ph == 2)
            begin
                write_reg(CFG_IDX_W'(REG_LEN_0 + VOICES), CFG_DW'($urandom));
                write_reg(CFG_IDX_W'(REG_LEN_0 + VOICES + 1), CFG_DW'($urandom));
            end
            // every accepted beat counts, fills included
            start_beats = beats_total();
            while (beats_total() - start_beats < PHASE_BEATS)
                random_beat();
        end
    endtask

    initial
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            len_shadow[v] = '0;
            stop_voice(v);
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_mix_extremes();
        test_notes_and_choke();
        test_bad_loads();
        test_length_change();
        test_random_traffic();
        drain();

        $display("covered %0d ticks, %0d note-ons, %0d sample loads, %0d unused actions",
                 ticks_sent, notes_sent, loads_sent, unused_sent);
        $display("checked %0d mix results, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0 && expected_mix_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d mix results pending", expected_mix_q.size());
        $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/dsvm_pkg.sv
hw/rtl/dsvm_sample_mem.sv
hw/rtl/dsvm_voice_ctrl.sv
hw/rtl/dsvm_mix.sv
hw/rtl/drum_sample_voice_mixer_core.sv
hw/rtl/dsvm_checker.sv
sim/tb.sv
